FILE: sv/websocket_frame_deframer_core_defines.svh
// ---------------------------------------------------------------------------
// websocket frame deframer assertion macros
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define WSD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/wsd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsd_pkg
// types and codes shared by the websocket frame deframer
// ---------------------------------------------------------------------------
package wsd_pkg;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_SECOND,
		PH_EXTLEN,
		PH_MASK,
		PH_PAYLOAD,
		PH_ERROR
	} phase_t;

	typedef enum logic [1:0] {
		FORM_SHORT,
		FORM_16,
		FORM_64
	} len_form_t;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_TOP_BIT     = 2'd0,
		ERR_NON_MINIMAL = 2'd1,
		ERR_RESERVED    = 2'd2,
		ERR_LONG_CTRL   = 2'd3
	} err_code_t;

	localparam logic [6:0]  LEN_CODE_16    = 7'd126;
	localparam logic [6:0]  LEN_CODE_64    = 7'd127;
	localparam logic [63:0] MAX_CTRL_LEN   = 64'd125;
	localparam logic [63:0] MIN_LEN_16     = 64'd126;
	localparam logic [3:0]  EXT16_BYTES    = 4'd2;
	localparam logic [3:0]  EXT64_BYTES    = 4'd8;
	localparam logic [2:0]  MASK_KEY_BYTES = 3'd4;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  frame_opcode;
		logic        final_fragment;
		logic        masked;
		logic [62:0] frame_payload_length;
		logic [7:0]  payload_byte;
		logic        last;
		err_code_t   error_code;
	} result_t;

endpackage

FILE: sv/wsd_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsd_in_if
// stream byte channel into the deframer
// ---------------------------------------------------------------------------
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       resync;

	modport source (output valid, output stream_byte, output resync, input ready);
	modport sink (input valid, input stream_byte, input resync, output ready);
endinterface

FILE: sv/wsd_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsd_out_if
// result channel out of the deframer
// ---------------------------------------------------------------------------
interface wsd_out_if;
	import wsd_pkg::*;

	logic        valid;
	logic        ready;
	kind_t       kind;
	logic [3:0]  frame_opcode;
	logic        final_fragment;
	logic        masked;
	logic [62:0] frame_payload_length;
	logic [7:0]  payload_byte;
	logic        last;
	err_code_t   error_code;

	modport source (output valid, output kind, output frame_opcode, output final_fragment,
		output masked, output frame_payload_length, output payload_byte, output last,
		output error_code, input ready);
	modport sink (input valid, input kind, input frame_opcode, input final_fragment,
		input masked, input frame_payload_length, input payload_byte, input last,
		input error_code, output ready);
endinterface

FILE: sv/websocket_frame_deframer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// websocket_frame_deframer_core
// parses a websocket byte stream into header, payload and error results
// ---------------------------------------------------------------------------
// stream: one raw byte per beat, with resync to restart at a frame's first byte
// result: header beat when the header is complete, one beat per payload byte
//   (unmasked with the key byte in rotation), or one error beat that sticks
//   until the next resync; last marks the final beat of a frame
// results are registered, in the result register or, while one waits, the skid register
// throughput: one byte per cycle while stream.ready is high; every byte is
//   decoded in the cycle it is taken, the parser state updates at that edge
// header bytes other than the final one give no result beat
// a result register and a one-entry skid register sit on the result side, so
//   stream keeps taking bytes while one result waits; stream.ready drops only
//   when both hold a result
// reset: parser waits for a first header byte, no error, result side empty
// ---------------------------------------------------------------------------
`include "websocket_frame_deframer_core_defines.svh"

module websocket_frame_deframer_core (
	input logic      clk,
	input logic      arst_n,
	wsd_in_if.sink   stream,
	wsd_out_if.source result
);
	import wsd_pkg::*;

	phase_t      phase_q;
	len_form_t   form_q;
	logic [3:0]  len_left_q;
	logic [63:0] len_acc_q;
	logic [8:0]  hdr_q;
	logic [31:0] key_q;
	logic [2:0]  mask_left_q;
	logic [62:0] remain_q;
	logic [1:0]  idx_q;

	phase_t      n_phase;
	len_form_t   n_form;
	logic [3:0]  n_len_left;
	logic [63:0] n_len_acc;
	logic [8:0]  n_hdr;
	logic [31:0] n_key;
	logic [2:0]  n_mask_left;
	logic [62:0] n_remain;
	logic [1:0]  n_idx;

	result_t     res;
	logic        res_vld;
	logic        do_finish;
	logic        do_header;
	logic        err_found;
	err_code_t   err_code;
	logic [7:0]  key_byte;
	phase_t      cur_phase;

	result_t     out_q;
	logic        out_valid_q;
	result_t     skid_q;
	logic        skid_valid_q;

	logic        acc;
	logic        take;
	logic [7:0]  b;

	assign b            = stream.stream_byte;
	assign stream.ready = !skid_valid_q;
	assign acc          = stream.valid && stream.ready;
	assign take         = result.valid && result.ready;

	always_comb begin
		case (idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		n_phase     = phase_q;
		n_form      = form_q;
		n_len_left  = len_left_q;
		n_len_acc   = len_acc_q;
		n_hdr       = hdr_q;
		n_key       = key_q;
		n_mask_left = mask_left_q;
		n_remain    = remain_q;
		n_idx       = idx_q;
		do_finish   = 1'b0;
		do_header   = 1'b0;
		res_vld     = 1'b0;
		err_found   = 1'b0;
		err_code    = ERR_TOP_BIT;
		cur_phase   = stream.resync ? PH_FIRST : phase_q;
		res         = '{kind: KIND_HEADER, frame_opcode: 4'd0, final_fragment: 1'b0,
			masked: 1'b0, frame_payload_length: 63'd0, payload_byte: 8'd0, last: 1'b0,
			error_code: ERR_TOP_BIT};

		if (acc) begin
			case (cur_phase)
				PH_FIRST: begin
					n_hdr       = {b, 1'b0};
					n_key       = 32'd0;
					n_idx       = 2'd0;
					n_len_acc   = 64'd0;
					n_len_left  = 4'd0;
					n_mask_left = 3'd0;
					n_remain    = 63'd0;
					n_form      = FORM_SHORT;
					n_phase     = PH_SECOND;
				end
				PH_SECOND: begin
					n_hdr = {hdr_q[8:1], b[7]};
					if (b[6:0] == LEN_CODE_16) begin
						n_form     = FORM_16;
						n_len_left = EXT16_BYTES;
						n_phase    = PH_EXTLEN;
					end else if (b[6:0] == LEN_CODE_64) begin
						n_form     = FORM_64;
						n_len_left = EXT64_BYTES;
						n_phase    = PH_EXTLEN;
					end else begin
						n_form    = FORM_SHORT;
						n_len_acc = {57'd0, b[6:0]};
						do_finish = 1'b1;
					end
				end
				PH_EXTLEN: begin
					n_len_acc  = {len_acc_q[55:0], b};
					n_len_left = len_left_q - 4'd1;
					do_finish  = (len_left_q == 4'd1);
				end
				PH_MASK: begin
					n_key       = {key_q[23:0], b};
					n_mask_left = mask_left_q - 3'd1;
					do_header   = (mask_left_q == 3'd1);
				end
				PH_PAYLOAD: begin
					n_idx    = idx_q + 2'd1;
					n_remain = remain_q - 63'd1;
					if (remain_q == 63'd1) begin
						n_phase = PH_FIRST;
					end
					res_vld              = 1'b1;
					res.kind             = KIND_PAYLOAD;
					res.payload_byte     = b ^ key_byte;
					res.last             = (remain_q == 63'd1);
				end
				PH_ERROR: begin
					n_phase = PH_ERROR;
				end
				default: begin
					n_phase = PH_FIRST;
				end
			endcase

			if (do_finish) begin
				if (n_form == FORM_64 && n_len_acc[63]) begin
					err_found = 1'b1;
					err_code  = ERR_TOP_BIT;
				end else if ((n_form == FORM_64 && n_len_acc[63:16] == 48'd0) ||
						(n_form == FORM_16 && n_len_acc < MIN_LEN_16)) begin
					err_found = 1'b1;
					err_code  = ERR_NON_MINIMAL;
				end else if (n_hdr[7:5] != 3'd0) begin
					err_found = 1'b1;
					err_code  = ERR_RESERVED;
				end else if (n_hdr[4] && n_len_acc > MAX_CTRL_LEN) begin
					err_found = 1'b1;
					err_code  = ERR_LONG_CTRL;
				end
				if (err_found) begin
					res_vld        = 1'b1;
					res.kind       = KIND_ERROR;
					res.last       = 1'b1;
					res.error_code = err_code;
					n_phase        = PH_ERROR;
				end else begin
					n_remain = n_len_acc[62:0];
					if (n_hdr[0]) begin
						n_mask_left = MASK_KEY_BYTES;
						n_phase     = PH_MASK;
					end else begin
						do_header = 1'b1;
					end
				end
			end

			if (do_header) begin
				res_vld  = 1'b1;
				res.kind = KIND_HEADER;
				res.last = (n_remain == 63'd0);
				n_phase  = (n_remain == 63'd0) ? PH_FIRST : PH_PAYLOAD;
			end

			res.frame_opcode         = n_hdr[4:1];
			res.final_fragment       = n_hdr[8];
			res.masked               = n_hdr[0];
			res.frame_payload_length = n_len_acc[62:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			form_q      <= FORM_SHORT;
			len_left_q  <= 4'd0;
			len_acc_q   <= 64'd0;
			hdr_q       <= 9'd0;
			key_q       <= 32'd0;
			mask_left_q <= 3'd0;
			remain_q    <= 63'd0;
			idx_q       <= 2'd0;
		end else if (acc) begin
			phase_q     <= n_phase;
			form_q      <= n_form;
			len_left_q  <= n_len_left;
			len_acc_q   <= n_len_acc;
			hdr_q       <= n_hdr;
			key_q       <= n_key;
			mask_left_q <= n_mask_left;
			remain_q    <= n_remain;
			idx_q       <= n_idx;
		end
	end

	// result register plus skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (acc && res_vld) begin
				out_valid_q <= 1'b1;
			end else if (take && !skid_valid_q) begin
				out_valid_q <= 1'b0;
			end
			if (take && skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (acc && res_vld && out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && skid_valid_q) begin
			out_q <= skid_q;
		end
		if (acc && res_vld) begin
			if (out_valid_q && !take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign result.valid                = out_valid_q;
	assign result.kind                 = out_q.kind;
	assign result.frame_opcode         = out_q.frame_opcode;
	assign result.final_fragment       = out_q.final_fragment;
	assign result.masked               = out_q.masked;
	assign result.frame_payload_length = out_q.frame_payload_length;
	assign result.payload_byte         = out_q.payload_byte;
	assign result.last                 = out_q.last;
	assign result.error_code           = out_q.error_code;

	`WSD_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q, "skid holds a beat ahead of the result register")
	`WSD_ASSERT_IMPL(a_error_is_last, out_valid_q && out_q.kind == KIND_ERROR, out_q.last, "error beat without last")
	`WSD_ASSERT_IMPL(a_payload_nonzero, phase_q == PH_PAYLOAD, remain_q != 63'd0, "payload phase with nothing left")
	`WSD_ASSERT_NEXT(a_resync_restarts, acc && stream.resync, phase_q == PH_SECOND, "resync byte not taken as first header byte")

endmodule
